### rtl/sha1sh_pkg.sv
// Shared types, constants and helpers for the SHA-1 stream hasher.
package sha1sh_pkg;

   // Chaining state after reset and at the start of every message
   localparam logic [4:0][31:0] SHA1_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [31:0] K_CH  = 32'h5a827999;
   localparam logic [31:0] K_PA1 = 32'h6ed9eba1;
   localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
   localparam logic [31:0] K_PA2 = 32'hca62c1d6;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned LEN_OFFSET  = 56;
   localparam int unsigned ROUNDS      = 80;
   localparam int unsigned DIGEST_WORDS = 5;

   // Round group: selects the boolean function and round constant
   typedef enum logic [1:0] {
      PH_CH  = 2'd0,
      PH_PA1 = 2'd1,
      PH_MAJ = 2'd2,
      PH_PA2 = 2'd3
   } phase_type;

   // Source of a byte shifted into the block window
   typedef enum logic [1:0] {
      BSEL_DATA = 2'd0,
      BSEL_MARK = 2'd1,
      BSEL_ZERO = 2'd2,
      BSEL_LEN  = 2'd3
   } byte_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic         shift_byte;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         add_len;
      logic         load_rounds;
      logic         do_round;
      phase_type    phase;
      logic         fold;
      logic         clear_msg;
      logic [2:0]   word_idx;
   } cmd_type;

   function automatic logic [31:0] round_k(input phase_type ph);
      logic [31:0] k;
      case (ph)
         PH_CH:   k = K_CH;
         PH_PA1:  k = K_PA1;
         PH_MAJ:  k = K_MAJ;
         default: k = K_PA2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] round_f(input phase_type ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (ph)
         PH_CH:   f = (b & c) | (~b & d);
         PH_MAJ:  f = (b & c) | (b & d) | (c & d);
         default: f = b ^ c ^ d;
      endcase
      return f;
   endfunction

endpackage

### rtl/sha1_stream_hasher_core.sv
// Top level of the SHA-1 stream hasher: controller plus datapath.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  req     | valid, stall, data_byte, has_byte, last       | in
//  rsp     | valid, stall, digest_word, word_index, last_word | out
//
// A byte beat that does not complete a block only shifts the byte in; a beat
// that completes a 64-byte block runs 80 rounds on the single round unit and
// then a fold. On a last beat, padding enters one byte a cycle up to the
// block end, and each padded block runs the rounds and a fold; then come five
// digest beats. Reset clears the chaining state, bit length and fill count.
// req_stall is high whenever the block is busy or digest words are pending;
// a stalled digest beat holds its word until taken.
module sha1_stream_hasher_core
   import sha1sh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   cmd_type cmd;

   sha1sh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_has_byte   (req_has_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd)
   );

   sha1sh_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule

### rtl/sha1sh_dp.sv
// Datapath: block window, round registers, chaining state and bit length.
module sha1sh_dp
   import sha1sh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [7:0]  req_data_byte,
   output logic [31:0] rsp_digest_word
);

   // Block window: word 0 sits in the top 32 bits, bytes enter at the bottom
   logic [511:0]     window_ff, window_in;
   logic [4:0][31:0] rnd_ff, rnd_in;
   logic [4:0][31:0] chain_ff, chain_in;
   logic [63:0]      len_ff, len_in;

   logic [7:0]  byte_mux;
   logic [7:0]  len_byte;
   logic [31:0] w0, w2, w8, w13, sched_xor, sched_new;
   logic [31:0] t_sum;

   // Length byte, most significant first
   assign len_byte = 8'(len_ff >> {~cmd.len_idx, 3'b000});

   always_comb begin
      case (cmd.byte_sel)
         BSEL_DATA: byte_mux = req_data_byte;
         BSEL_MARK: byte_mux = PAD_MARK;
         BSEL_LEN:  byte_mux = len_byte;
         default:   byte_mux = 8'h00;
      endcase
   end

   // Message schedule taps at fixed places of the window
   assign w0  = window_ff[511 -: 32];
   assign w2  = window_ff[511 - 64 -: 32];
   assign w8  = window_ff[511 - 256 -: 32];
   assign w13 = window_ff[511 - 416 -: 32];
   assign sched_xor = w13 ^ w8 ^ w2 ^ w0;
   assign sched_new = {sched_xor[30:0], sched_xor[31]};

   // One compression round
   assign t_sum = {rnd_ff[0][26:0], rnd_ff[0][31:27]}
                + round_f(cmd.phase, rnd_ff[1], rnd_ff[2], rnd_ff[3])
                + rnd_ff[4] + round_k(cmd.phase) + w0;

   always_comb begin
      window_in = window_ff;
      if (cmd.shift_byte) begin
         window_in = {window_ff[503:0], byte_mux};
      end else if (cmd.do_round) begin
         window_in = {window_ff[479:0], sched_new};
      end
   end

   always_comb begin
      rnd_in = rnd_ff;
      if (cmd.load_rounds) begin
         rnd_in = chain_ff;
      end else if (cmd.do_round) begin
         rnd_in[0] = t_sum;
         rnd_in[1] = rnd_ff[0];
         rnd_in[2] = {rnd_ff[1][1:0], rnd_ff[1][31:2]};
         rnd_in[3] = rnd_ff[2];
         rnd_in[4] = rnd_ff[3];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      len_in   = len_ff;
      if (cmd.clear_msg) begin
         chain_in = SHA1_INIT;
         len_in   = '0;
      end else begin
         if (cmd.fold) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + rnd_ff[i];
            end
         end
         if (cmd.add_len) begin
            len_in = len_ff + 64'd8;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      window_ff <= window_in;
      rnd_ff    <= rnd_in;
   end

   // Message state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= SHA1_INIT;
         len_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         len_ff   <= len_in;
      end
   end

   // Digest word select
   always_comb begin
      case (cmd.word_idx)
         3'd1:    rsp_digest_word = chain_ff[1];
         3'd2:    rsp_digest_word = chain_ff[2];
         3'd3:    rsp_digest_word = chain_ff[3];
         3'd4:    rsp_digest_word = chain_ff[4];
         default: rsp_digest_word = chain_ff[0];
      endcase
   end

endmodule

### rtl/sha1sh_ctrl.sv
// Controller: handshakes, byte fill, padding sequence and round counting.
module sha1sh_ctrl
   import sha1sh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_has_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_word_index,
   output logic       rsp_last_word,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       last_ff, last_in;    // message closes after the current block
   logic       mark_ff, mark_in;    // 0x80 marker already placed
   logic       extra_ff, extra_in;  // marker left no room for the length
   logic       final_ff, final_in;  // block in flight carries the length

   logic req_accept, rsp_accept;
   logic len_zone;

   assign req_stall      = reset || (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign req_accept     = req_valid && !req_stall;
   assign rsp_accept     = rsp_valid && !rsp_stall;
   assign rsp_word_index = word_ff;
   assign rsp_last_word  = (word_ff == 3'(DIGEST_WORDS - 1));
   assign len_zone       = (fill_ff >= 6'(LEN_OFFSET));

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      mark_in  = mark_ff;
      extra_in = extra_ff;
      final_in = final_ff;
      cmd      = '0;
      cmd.byte_sel = BSEL_DATA;
      cmd.phase    = PH_CH;
      cmd.len_idx  = fill_ff[2:0];
      cmd.word_idx = word_ff;

      case (round_ff) inside
         [7'd0:7'd19]:  cmd.phase = PH_CH;
         [7'd20:7'd39]: cmd.phase = PH_PA1;
         [7'd40:7'd59]: cmd.phase = PH_MAJ;
         default:       cmd.phase = PH_PA2;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_has_byte) begin
                  cmd.shift_byte = 1'b1;
                  cmd.add_len    = 1'b1;
                  fill_in        = fill_ff + 6'd1;
                  if (fill_ff == 6'(BLOCK_BYTES - 1)) begin
                     cmd.load_rounds = 1'b1;
                     last_in  = req_last;
                     final_in = 1'b0;
                     state_in = ST_ROUND;
                  end else if (req_last) begin
                     last_in  = 1'b1;
                     state_in = ST_PAD;
                  end
               end else if (req_last) begin
                  last_in  = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.shift_byte = 1'b1;
            if (!mark_ff) begin
               cmd.byte_sel = BSEL_MARK;
            end else if (extra_ff || !len_zone) begin
               cmd.byte_sel = BSEL_ZERO;
            end else begin
               cmd.byte_sel = BSEL_LEN;
            end
            mark_in  = 1'b1;
            extra_in = extra_ff || (!mark_ff && len_zone);
            fill_in  = fill_ff + 6'd1;
            if (fill_ff == 6'(BLOCK_BYTES - 1)) begin
               cmd.load_rounds = 1'b1;
               final_in = !extra_in;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               round_in = '0;
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (final_ff) begin
               word_in  = '0;
               state_in = ST_OUT;
            end else begin
               extra_in = 1'b0;
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_accept) begin
               if (word_ff == 3'(DIGEST_WORDS - 1)) begin
                  cmd.clear_msg = 1'b1;
                  word_in  = '0;
                  last_in  = 1'b0;
                  mark_in  = 1'b0;
                  extra_in = 1'b0;
                  final_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         word_ff  <= '0;
         last_ff  <= 1'b0;
         mark_ff  <= 1'b0;
         extra_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         last_ff  <= last_in;
         mark_ff  <= mark_in;
         extra_ff <= extra_in;
         final_ff <= final_in;
      end
   end

`ifndef SYNTHESIS
   // Input is never taken while digest words are on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("input accepted while digest pending");

   // Folding only after the eightieth round
   a_fold_after_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> $past(state_ff == ST_ROUND && round_ff == 7'(ROUNDS - 1)))
      else $error("fold without full round sequence");

   // Digest words only after the length-carrying block
   a_out_needs_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (last_ff && final_ff && mark_ff && fill_ff == 6'd0))
      else $error("digest without final block");

   // Word index stays within the digest
   a_word_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (word_ff <= 3'(DIGEST_WORDS - 1)))
      else $error("digest word index out of range");
`endif

endmodule

### sim/tb_sha1_stream_hasher_core.sv
// Self-checking testbench for the SHA-1 stream hasher core: directed table plus random messages.
module tb_sha1_stream_hasher_core
   import sha1sh_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 8;
   localparam int HOLD_CYCLES = 600;
   localparam int PHASE_ITEMS = 75;
   localparam int DRAIN_CYCLES = 200;

   // Known digests, h0 first
   localparam logic [0:4][31:0] EMPTY_DIGEST =
      {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709};
   localparam logic [0:4][31:0] ABC_DIGEST =
      {32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d};

   // One directed beat; known rows carry the digest that must come out
   typedef struct packed {
      logic [7:0]       data;
      logic             has;
      logic             fin;
      logic             known;
      logic [0:4][31:0] digest;
   } dir_row_type;

   localparam int DIR_ROWS = 16;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
      '{8'hff, 1'b0, 1'b0, 1'b0, '0},            // idle beat, data ignored
      '{8'h61, 1'b1, 1'b0, 1'b0, '0},
      '{8'h62, 1'b1, 1'b0, 1'b0, '0},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // byte and last together
      '{8'h00, 1'b1, 1'b1, 1'b0, '0},            // lone zero byte
      '{8'hff, 1'b1, 1'b1, 1'b0, '0},            // lone all-ones byte
      '{8'hff, 1'b1, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},            // idle in mid-message
      '{8'h80, 1'b1, 1'b0, 1'b0, '0},
      '{8'h7f, 1'b0, 1'b1, 1'b0, '0},            // close without a byte
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // state cleared after a message
      '{8'h01, 1'b1, 1'b0, 1'b0, '0},
      '{8'hfe, 1'b1, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, 1'b0, '0},
      '{8'haa, 1'b1, 1'b1, 1'b0, '0}
   };

   // Idling per random phase, and the message length that opens each phase
   localparam int SEND_IDLE [4] = '{0, 55, 0, 13};
   localparam int RECV_STALL [4] = '{0, 0, 55, 13};
   localparam int BOUNDARY_LEN [4] = '{55, 56, 63, 64};

   typedef struct {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        lastw;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // Predicted hasher state
   logic [7:0]  msg_buf [BLOCK_BYTES];
   int unsigned msg_fill;
   logic [31:0] chain [DIGEST_WORDS];
   logic [63:0] msg_bits;

   digest_beat_type digest_q [$];

   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;
   int unsigned bytes_sent = 0;
   int unsigned messages_closed = 0;
   int unsigned words_checked = 0;
   int unsigned longest_msg = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          hold_req = 1'b0;

   sha1_stream_hasher_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #2ms;
      $display("tb_sha1_stream_hasher_core: errors");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void clear_msg();
      msg_fill = 0;
      msg_bits = '0;
      for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = SHA1_INIT[i];
   endfunction

   // 80-round compression of the 64-byte buffer into the chaining words
   function automatic void fold_block();
      logic [31:0] w [ROUNDS];
      logic [31:0] a, b, c, d, e, f, k, t;
      phase_type   grp;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
      for (int i = 16; i < ROUNDS; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < ROUNDS; r++) begin
         grp = phase_type'(r / 20);
         case (grp)
            PH_CH: begin
               f = (b & c) | (~b & d);
               k = K_CH;
            end
            PH_PA1: begin
               f = b ^ c ^ d;
               k = K_PA1;
            end
            PH_MAJ: begin
               f = (b & c) | (b & d) | (c & d);
               k = K_MAJ;
            end
            default: begin
               f = b ^ c ^ d;
               k = K_PA2;
            end
         endcase
         t = rotl(a, 5) + f + e + k + w[r];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   // Update the predicted state for one accepted beat; queue the digest on last
   function automatic void absorb_beat(input logic [7:0] data, input logic has,
                                       input logic fin, input logic known,
                                       input logic [0:4][31:0] typed);
      digest_beat_type beat;
      if (has) begin
         msg_buf[msg_fill] = data;
         msg_fill++;
         msg_bits += 64'd8;
         if (msg_fill == BLOCK_BYTES) begin
            fold_block();
            msg_fill = 0;
         end
      end
      if (!fin) return;
      // padding: marker, zeros, then the bit length big-endian
      msg_buf[msg_fill] = PAD_MARK;
      msg_fill++;
      if (msg_fill > LEN_OFFSET) begin
         while (msg_fill < BLOCK_BYTES) begin
            msg_buf[msg_fill] = 8'h00;
            msg_fill++;
         end
         fold_block();
         msg_fill = 0;
      end
      while (msg_fill < LEN_OFFSET) begin
         msg_buf[msg_fill] = 8'h00;
         msg_fill++;
      end
      for (int i = 0; i < 8; i++) msg_buf[LEN_OFFSET + i] = msg_bits[63 - 8*i -: 8];
      fold_block();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         beat.word  = known ? typed[i] : chain[i];
         beat.idx   = 3'(i);
         beat.lastw = (i == DIGEST_WORDS - 1);
         digest_q = {digest_q, beat};
      end
      messages_closed++;
      clear_msg();
   endfunction

   // Offer one beat, with random idle cycles first, and hold it until taken
   task automatic send_beat(input logic [7:0] data, input logic has, input logic fin,
                            input logic known, input logic [0:4][31:0] typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_has_byte  <= has;
      req_last      <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_beat(data, has, fin, known, typed);
      if (has || fin) items_sent++;
   endtask

   function automatic int unsigned pick_length();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70) return $urandom_range(10);
      if (sel < 90) return $urandom_range(65, 54);
      return $urandom_range(130, 100);
   endfunction

   // Random message; the last beat either carries a byte or is a bare close
   task automatic send_message(input int unsigned len);
      logic close_on_byte;
      close_on_byte = (len != 0) && ($urandom_range(1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(99) < 6) send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
         send_beat(8'($urandom), 1'b1, close_on_byte && (i == len - 1), 1'b0, '0);
      end
      if (!close_on_byte) send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      bytes_sent += len;
      if (len > longest_msg) longest_msg = len;
   endtask

   // Receiver: random stall, or one long hold-off when asked
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Digest beat check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      digest_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_q.size() == 0) begin
            report_mismatch($sformatf("digest beat %08h with nothing expected",
                                      rsp_digest_word));
         end else begin
            want = digest_q.pop_front();
            words_checked++;
            if (rsp_digest_word !== want.word)
               report_mismatch($sformatf("word %0d: digest %08h, expected %08h",
                                         want.idx, rsp_digest_word, want.word));
            if (rsp_word_index !== want.idx)
               report_mismatch($sformatf("word index %0d, expected %0d",
                                         rsp_word_index, want.idx));
            if (rsp_last_word !== want.lastw)
               report_mismatch($sformatf("word %0d: last flag %b, expected %b",
                                         want.idx, rsp_last_word, want.lastw));
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_start;
      clear_msg();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling
      for (int i = 0; i < DIR_ROWS; i++)
         send_beat(DIRECTED[i].data, DIRECTED[i].has, DIRECTED[i].fin,
                   DIRECTED[i].known, DIRECTED[i].digest);

      // random phases; the first one carries the long receiver hold-off
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE[p];
         stall_pct     = RECV_STALL[p];
         if (p == 0) hold_req = 1'b1;
         phase_start = items_sent;
         send_message(BOUNDARY_LEN[p]);
         while (items_sent - phase_start < PHASE_ITEMS) send_message(pick_length());
      end
      req_valid <= 1'b0;

      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d beats, %0d message bytes, %0d messages, longest %0d bytes",
               items_sent, bytes_sent, messages_closed, longest_msg);
      $display("run: %0d digest words checked; idle/stall phases and a %0d-cycle hold-off",
               words_checked, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("tb_sha1_stream_hasher_core: clean");
      end else begin
         $display("tb_sha1_stream_hasher_core: errors");
      end
      $finish;
   end

endmodule
